// ===== rtl/ars_pkg.sv =====
package ars_pkg;

  // Command codes carried in the cmd field of an input word.
  typedef enum logic [1:0] {
    CMD_RX      = 2'd0,
    CMD_ARM_OK  = 2'd1,
    CMD_ARM_SRV = 2'd2
  } cmd_t;

  // Phase of the server response matcher.
  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_WAIT_IPD = 2'd1,
    PH_CAPTURE  = 2'd2
  } phase_t;

  // Size of the response buffer and the widths of its index and length.
  localparam int CAPTURE_DEPTH = 1024;
  localparam int IDX_W = (CAPTURE_DEPTH > 1) ? $clog2(CAPTURE_DEPTH) : 1;
  localparam int LEN_W = $clog2(CAPTURE_DEPTH + 1);

  // Lengths of the three match texts.
  localparam logic [2:0] OK_LEN   = 3'd4;
  localparam logic [2:0] IPD_LEN  = 3'd5;
  localparam logic [2:0] TERM_LEN = 3'd6;

  // Bit that turns an upper case letter into lower case.
  localparam logic [7:0] CASE_BIT = 8'h20;

  // Lowercases only the letters A to Z.
  function automatic logic [7:0] to_lower(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= 8'h41 && b <= 8'h5A) begin
      r = b | CASE_BIT;
    end
    return r;
  endfunction

  // Character of "ok\r\n" at a position.
  function automatic logic [7:0] ok_char(input logic [1:0] pos);
    logic [7:0] c;
    unique case (pos)
      2'd0:    c = 8'h6F;
      2'd1:    c = 8'h6B;
      2'd2:    c = 8'h0D;
      default: c = 8'h0A;
    endcase
    return c;
  endfunction

  // Character of "+ipd," at a position.
  function automatic logic [7:0] ipd_char(input logic [2:0] pos);
    logic [7:0] c;
    unique case (pos)
      3'd0:    c = 8'h2B;
      3'd1:    c = 8'h69;
      3'd2:    c = 8'h70;
      3'd3:    c = 8'h64;
      default: c = 8'h2C;
    endcase
    return c;
  endfunction

  // Character of "\n\rok\r\n" at a position.
  function automatic logic [7:0] term_char(input logic [2:0] pos);
    logic [7:0] c;
    unique case (pos)
      3'd0:    c = 8'h0A;
      3'd1:    c = 8'h0D;
      3'd2:    c = 8'h6F;
      3'd3:    c = 8'h6B;
      3'd4:    c = 8'h0D;
      default: c = 8'h0A;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/ars_if.sv =====
// Input channel: one command or received byte per word.
interface ars_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] rx_byte;

  modport source (output valid, cmd, rx_byte, input ready);
  modport sink   (input valid, cmd, rx_byte, output ready);
endinterface

// Result channel: flags and capture information for one step.
interface ars_out_if;
  import ars_pkg::*;

  logic             valid;
  logic             ready;
  logic             ok_found;
  logic             response_complete;
  logic             capture_valid;
  logic [IDX_W-1:0] capture_index;
  logic [7:0]       capture_byte;
  logic [LEN_W-1:0] capture_length;

  modport source (output valid, ok_found, response_complete, capture_valid,
                  capture_index, capture_byte, capture_length, input ready);
  modport sink   (input valid, ok_found, response_complete, capture_valid,
                  capture_index, capture_byte, capture_length, output ready);
endinterface

// ===== rtl/at_response_scanner_unit.sv =====
// Channel    Dir  Handshake      Payload
// in_chan    in   valid/ready    cmd, rx_byte
// out_chan   out  valid/ready    ok_found, response_complete, capture_valid,
//                                capture_index, capture_byte, capture_length
//
// Each input word yields one registered result word, valid in the cycle after it is accepted.
// A new word is accepted every cycle while the result register is empty or
// being drained; the matchers and the capture counter update in that cycle.
// A stalled result holds the input side only while it is not taken.
// Synchronous active-low reset clears both matchers, the flags and the count.
module at_response_scanner_unit (
  input logic    clk,
  input logic    rst_n,
  ars_in_if.sink in_chan,
  ars_out_if.source out_chan
);
  import ars_pkg::*;

  localparam logic [LEN_W-1:0] DEPTH_L = LEN_W'(CAPTURE_DEPTH);

  // Matcher state.
  logic             ok_searching_r, ok_searching_nxt;
  logic [1:0]       ok_pos_r, ok_pos_nxt;
  logic             ok_flag_r, ok_flag_nxt;
  phase_t           phase_r, phase_nxt;
  logic [2:0]       srv_pos_r, srv_pos_nxt;
  logic             complete_r, complete_nxt;
  logic [LEN_W-1:0] count_r, count_nxt;

  // Result register.
  logic             out_valid_r;
  logic             ok_found_r;
  logic             complete_out_r;
  logic             cap_valid_r, cap_valid_nxt;
  logic [IDX_W-1:0] cap_index_r, cap_index_nxt;
  logic [7:0]       cap_byte_r, cap_byte_nxt;
  logic [LEN_W-1:0] cap_len_r;

  logic       accept;
  logic [7:0] b_low;
  logic       ok_hit;
  logic       srv_hit;
  logic       srv_last;
  logic [2:0] srv_len;
  logic [7:0] srv_char;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;
  assign b_low         = to_lower(in_chan.rx_byte);

  // Character compares for both matchers.
  assign ok_hit   = (ok_char(ok_pos_r) == b_low);
  assign srv_len  = (phase_r == PH_CAPTURE) ? TERM_LEN : IPD_LEN;
  assign srv_char = (phase_r == PH_CAPTURE) ? term_char(srv_pos_r) : ipd_char(srv_pos_r);
  assign srv_hit  = (srv_char == b_low);
  assign srv_last = srv_hit && ((srv_pos_r + 3'd1) == srv_len);

  // Next phase of the server matcher.
  always_comb begin
    phase_nxt = phase_r;
    unique case (in_chan.cmd)
      CMD_ARM_SRV: phase_nxt = PH_WAIT_IPD;
      CMD_RX: begin
        if (phase_r == PH_WAIT_IPD && srv_last) begin
          phase_nxt = PH_CAPTURE;
        end else if (phase_r == PH_CAPTURE && srv_last) begin
          phase_nxt = PH_IDLE;
        end
      end
      default: phase_nxt = phase_r;
    endcase
  end

  // Matcher positions, flags and capture outputs.
  always_comb begin
    ok_searching_nxt = ok_searching_r;
    ok_pos_nxt       = ok_pos_r;
    ok_flag_nxt      = ok_flag_r;
    srv_pos_nxt      = srv_pos_r;
    complete_nxt     = complete_r;
    count_nxt        = count_r;
    cap_valid_nxt    = 1'b0;
    cap_index_nxt    = '0;
    cap_byte_nxt     = '0;
    unique case (in_chan.cmd)
      CMD_ARM_OK: begin
        ok_pos_nxt       = '0;
        ok_flag_nxt      = 1'b0;
        ok_searching_nxt = 1'b1;
      end
      CMD_ARM_SRV: begin
        srv_pos_nxt  = '0;
        complete_nxt = 1'b0;
        count_nxt    = '0;
      end
      CMD_RX: begin
        if (ok_searching_r) begin
          if (ok_hit && ok_pos_r == 2'(OK_LEN - 3'd1)) begin
            ok_pos_nxt       = '0;
            ok_flag_nxt      = 1'b1;
            ok_searching_nxt = 1'b0;
          end else if (ok_hit) begin
            ok_pos_nxt = ok_pos_r + 2'd1;
          end else begin
            ok_pos_nxt = '0;
          end
        end
        if (phase_r == PH_WAIT_IPD || phase_r == PH_CAPTURE) begin
          if (srv_hit && !srv_last) begin
            srv_pos_nxt = srv_pos_r + 3'd1;
          end else begin
            srv_pos_nxt = '0;
          end
        end
        if (phase_r == PH_CAPTURE) begin
          if (count_r < DEPTH_L) begin
            cap_valid_nxt = 1'b1;
            cap_index_nxt = count_r[IDX_W-1:0];
            cap_byte_nxt  = b_low;
            count_nxt     = count_r + LEN_W'(1);
          end
          if (srv_last) begin
            complete_nxt = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Matcher state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ok_searching_r <= 1'b0;
      ok_pos_r       <= '0;
      ok_flag_r      <= 1'b0;
      phase_r        <= PH_IDLE;
      srv_pos_r      <= '0;
      complete_r     <= 1'b0;
      count_r        <= '0;
    end else if (accept) begin
      ok_searching_r <= ok_searching_nxt;
      ok_pos_r       <= ok_pos_nxt;
      ok_flag_r      <= ok_flag_nxt;
      phase_r        <= phase_nxt;
      srv_pos_r      <= srv_pos_nxt;
      complete_r     <= complete_nxt;
      count_r        <= count_nxt;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload, loaded with each accepted word.
  always_ff @(posedge clk) begin
    if (accept) begin
      ok_found_r     <= ok_flag_nxt;
      complete_out_r <= complete_nxt;
      cap_valid_r    <= cap_valid_nxt;
      cap_index_r    <= cap_index_nxt;
      cap_byte_r     <= cap_byte_nxt;
      cap_len_r      <= count_nxt;
    end
  end

  assign out_chan.valid             = out_valid_r;
  assign out_chan.ok_found          = ok_found_r;
  assign out_chan.response_complete = complete_out_r;
  assign out_chan.capture_valid     = cap_valid_r;
  assign out_chan.capture_index     = cap_index_r;
  assign out_chan.capture_byte      = cap_byte_r;
  assign out_chan.capture_length    = cap_len_r;

endmodule

// ===== rtl/ars_checker.sv =====
module ars_checker (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic [1:0]               in_cmd,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic                     out_ok_found,
  input logic                     out_response_complete,
  input logic                     out_capture_valid,
  input logic [ars_pkg::IDX_W-1:0] out_capture_index,
  input logic [ars_pkg::LEN_W-1:0] out_capture_length
);
  import ars_pkg::*;

  localparam logic [LEN_W-1:0] DEPTH_L = LEN_W'(CAPTURE_DEPTH);

  // A result word waits until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // A captured byte sits at the last position counted.
  a_cap_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_capture_valid |->
      (LEN_W'(out_capture_index) + LEN_W'(1)) == out_capture_length)
    else $error("capture index does not match capture length");

  // The capture count never passes the buffer depth.
  a_cap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_capture_length <= DEPTH_L)
    else $error("capture length beyond buffer depth");

  // Arming the ok search clears the found flag in its own result word.
  a_arm_ok: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_cmd == CMD_ARM_OK |=> out_valid && !out_ok_found)
    else $error("ok flag not cleared by arm");

  // Arming the server search clears the flag and the count.
  a_arm_srv: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_cmd == CMD_ARM_SRV |=>
      out_valid && !out_response_complete && out_capture_length == '0)
    else $error("server state not cleared by arm");

endmodule

bind at_response_scanner_unit ars_checker u_ars_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .in_valid              (in_chan.valid),
  .in_ready              (in_chan.ready),
  .in_cmd                (in_chan.cmd),
  .out_valid             (out_chan.valid),
  .out_ready             (out_chan.ready),
  .out_ok_found          (out_chan.ok_found),
  .out_response_complete (out_chan.response_complete),
  .out_capture_valid     (out_chan.capture_valid),
  .out_capture_index     (out_chan.capture_index),
  .out_capture_length    (out_chan.capture_length)
);

// ===== tb/sv/scan_result_checker.sv =====
// Watches both channels of the scanner. It keeps its own copy of the two
// matchers and the capture counter, predicts one result word per accepted
// input word and compares every accepted result word with the oldest one.
module scan_result_checker (
  input logic clk,
  input logic rst_n,
  ars_in_if   in_chan,
  ars_out_if  out_chan,
  output int  fail_count,
  output int  open_count
);
  import ars_pkg::*;

  localparam logic [7:0] CR = 8'h0D;
  localparam logic [7:0] LF = 8'h0A;

  // Match texts, right aligned: the last character sits in the lowest byte.
  localparam logic [47:0] OK_TXT   = {16'h0, "ok", CR, LF};
  localparam logic [47:0] IPD_TXT  = {8'h0, "+ipd,"};
  localparam logic [47:0] TERM_TXT = {LF, CR, "ok", CR, LF};

  typedef struct packed {
    logic             ok_found;
    logic             response_complete;
    logic             capture_valid;
    logic [IDX_W-1:0] capture_index;
    logic [7:0]       capture_byte;
    logic [LEN_W-1:0] capture_length;
  } scan_result_t;

  // Predicted scanner state.
  logic             ok_armed;
  logic [2:0]       ok_pos;
  logic             ok_seen;
  phase_t           srv_phase;
  logic [2:0]       srv_pos;
  logic             resp_done;
  logic [LEN_W-1:0] cap_count;

  scan_result_t pending_results[$];
  int           err_count;

  // One matcher step. Returns {hit, next position}. A mismatch goes back to
  // the start of the text without testing the same character again.
  function automatic logic [3:0] match_next(input logic [47:0] txt, input int len,
                                            input logic [2:0] pos, input logic [7:0] ch);
    logic [2:0] p;
    p = 3'd0;
    if (ch == txt[8*(len-1-pos) +: 8]) begin
      p = pos + 3'd1;
    end
    if (p >= len) begin
      return {1'b1, 3'd0};
    end
    return {1'b0, p};
  endfunction

  // Applies one input word to the predicted state and returns its result word.
  function automatic scan_result_t scan_word(input logic [1:0] cmd, input logic [7:0] raw);
    scan_result_t r;
    logic [7:0]   ch;
    logic [3:0]   m;
    ch = (raw >= "A" && raw <= "Z") ? (raw | CASE_BIT) : raw;
    r = '0;
    case (cmd)
      CMD_ARM_OK: begin
        ok_pos = 3'd0;
        ok_seen = 1'b0;
        ok_armed = 1'b1;
      end
      CMD_ARM_SRV: begin
        srv_phase = PH_WAIT_IPD;
        srv_pos = 3'd0;
        resp_done = 1'b0;
        cap_count = '0;
      end
      CMD_RX: begin
        if (ok_armed) begin
          m = match_next(OK_TXT, OK_LEN, ok_pos, ch);
          ok_pos = m[2:0];
          if (m[3]) begin
            ok_seen = 1'b1;
            ok_armed = 1'b0;
          end
        end
        if (srv_phase == PH_WAIT_IPD) begin
          m = match_next(IPD_TXT, IPD_LEN, srv_pos, ch);
          srv_pos = m[2:0];
          if (m[3]) begin
            srv_phase = PH_CAPTURE;
            srv_pos = 3'd0;
          end
        end else if (srv_phase == PH_CAPTURE) begin
          // The byte is stored before the terminator test, so the
          // terminator itself lands in the buffer too.
          if (cap_count < CAPTURE_DEPTH) begin
            r.capture_valid = 1'b1;
            r.capture_index = cap_count[IDX_W-1:0];
            r.capture_byte = ch;
            cap_count = cap_count + LEN_W'(1);
          end
          m = match_next(TERM_TXT, TERM_LEN, srv_pos, ch);
          srv_pos = m[2:0];
          if (m[3]) begin
            resp_done = 1'b1;
            srv_phase = PH_IDLE;
          end
        end
      end
      default: begin
        // The unused command leaves everything as it is.
      end
    endcase
    r.ok_found = ok_seen;
    r.response_complete = resp_done;
    r.capture_length = cap_count;
    return r;
  endfunction

  task automatic check_field(input string field, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want_v, got_v);
      err_count++;
    end
  endtask

  // Predict on every accepted input word, compare on every accepted result word.
  always @(posedge clk) begin
    scan_result_t want;
    if (!rst_n) begin
      ok_armed = 1'b0;
      ok_pos = 3'd0;
      ok_seen = 1'b0;
      srv_phase = PH_IDLE;
      srv_pos = 3'd0;
      resp_done = 1'b0;
      cap_count = '0;
      pending_results.delete();
      err_count = 0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        pending_results.push_back(scan_word(in_chan.cmd, in_chan.rx_byte));
      end
      if (out_chan.valid && out_chan.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result word with none expected, length %0d", $time,
                   out_chan.capture_length);
          err_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("ok_found", want.ok_found, out_chan.ok_found);
          check_field("response_complete", want.response_complete,
                      out_chan.response_complete);
          check_field("capture_valid", want.capture_valid, out_chan.capture_valid);
          check_field("capture_index", want.capture_index, out_chan.capture_index);
          check_field("capture_byte", want.capture_byte, out_chan.capture_byte);
          check_field("capture_length", want.capture_length, out_chan.capture_length);
        end
      end
    end
    fail_count <= err_count;
    open_count <= pending_results.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
module tb;
  import ars_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 100;
  localparam int IDLE_LIMIT  = 3000;
  localparam int TAIL_CYCLES = 10;
  localparam int FILL_BYTES  = 1040;

  logic clk;
  logic rst_n;

  ars_in_if  in_ch();
  ars_out_if out_ch();

  int fail_count;
  int open_count;
  int sent_words;
  int snd_idle_pct;
  int rcv_idle_pct;
  bit hold_req;
  int idle_cycles;

  at_response_scanner_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  scan_result_checker result_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_ch),
    .out_chan   (out_ch),
    .fail_count (fail_count),
    .open_count (open_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offers one word, with random gaps before it, and waits until it is taken.
  task automatic send_word(input logic [1:0] c, input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.cmd = c;
    in_ch.rx_byte = b;
    do @(posedge clk); while (!in_ch.ready);
    sent_words++;
  endtask

  // Sends a text as received bytes, letters in random case.
  task automatic send_text(input string s);
    logic [7:0] b;
    for (int i = 0; i < s.len(); i++) begin
      b = s[i];
      if (b >= "a" && b <= "z" && $urandom_range(1) == 1) begin
        b = b & ~CASE_BIT;
      end
      send_word(CMD_RX, b);
    end
  endtask

  // Half the time characters of the match texts, otherwise any byte.
  function automatic logic [7:0] pick_byte();
    string charset;
    charset = "oOkK\015\012+iIpPdD,";
    if ($urandom_range(1) == 0) begin
      return charset[$urandom_range(charset.len() - 1)];
    end
    return 8'($urandom_range(255));
  endfunction

  // Mostly received bytes, now and then any command with any byte.
  task automatic send_noise(input int n);
    repeat (n) begin
      if ($urandom_range(9) < 7) begin
        send_word(CMD_RX, pick_byte());
      end else begin
        send_word(2'($urandom_range(3)), 8'($urandom_range(255)));
      end
    end
  endtask

  // One random exchange: an ok reply, a server response, both, or noise.
  task automatic run_sequence();
    int kind;
    kind = $urandom_range(9);
    if (kind <= 2) begin
      if ($urandom_range(7) != 0) begin
        send_word(CMD_ARM_OK, 8'($urandom_range(255)));
      end
      send_noise($urandom_range(4));
      if ($urandom_range(2) == 0) begin
        send_text("ok\015");
      end
      send_text("ok\015\012");
    end else if (kind <= 7) begin
      send_word(CMD_ARM_SRV, 8'($urandom_range(255)));
      if (kind == 7) begin
        send_word(CMD_ARM_OK, 8'($urandom_range(255)));
      end
      send_noise($urandom_range(4));
      if ($urandom_range(3) == 0) begin
        send_text("+ip");
      end
      send_text("+ipd,");
      repeat ($urandom_range(24)) begin
        case ($urandom_range(9))
          0:       send_text("\012\015ok");
          1:       send_text("ok\015\012");
          default: send_word(CMD_RX, pick_byte());
        endcase
      end
      if ($urandom_range(7) != 0) begin
        send_text("\012\015ok\015\012");
      end
    end else begin
      send_noise(1 + $urandom_range(7));
    end
  endtask

  // Result side: random stalls, and one long hold-off on request.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        repeat (HOLD_CYCLES) begin
          out_ch.ready = 1'b0;
          @(negedge clk);
        end
        hold_req = 1'b0;
      end
      out_ch.ready = ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Ends the run when no word moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL at_response_scanner_unit");
      $finish;
    end
  end

  initial begin
    int mark;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_RX;
    in_ch.rx_byte = 8'h00;
    sent_words = 0;
    idle_cycles = 0;
    hold_req = 1'b0;
    snd_idle_pct = 13;
    rcv_idle_pct = 60;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: nothing armed, the unused command, an ok search broken by a
    // doubled letter, an upper case ok, then a full server response.
    send_word(CMD_RX, 8'h00);
    send_word(CMD_UNUSED, 8'hFF);
    send_word(CMD_ARM_OK, 8'h00);
    send_text("ook\015\012");
    send_text("OK\015\012");
    send_word(CMD_ARM_SRV, 8'hFF);
    send_text("+IPD,");
    send_word(CMD_RX, "Z");
    send_word(CMD_RX, 8'hFF);
    send_text("\012\015OK\015\012");

    // Random exchanges, first with sender gaps and a slow receiver.
    mark = sent_words;
    while (sent_words < mark + 200) run_sequence();

    snd_idle_pct = 60;
    rcv_idle_pct = 13;
    mark = sent_words;
    while (sent_words < mark + 200) run_sequence();

    // No idling. The receiver holds off for a while so the scanner backs up,
    // then one response runs past the end of the capture buffer.
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_req = 1'b1;
    send_word(CMD_ARM_SRV, 8'h00);
    send_text("+ipd,");
    repeat (FILL_BYTES) send_word(CMD_RX, 8'($urandom_range(255)));
    send_text("\012\015ok\015\012");
    mark = sent_words;
    while (sent_words < mark + 50) run_sequence();

    @(negedge clk);
    in_ch.valid = 1'b0;
    while (open_count != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && open_count == 0) begin
      $display("PASS at_response_scanner_unit");
    end else begin
      $display("FAIL at_response_scanner_unit");
    end
    $finish;
  end

endmodule
